@@ hdl/prrs_pkg.sv @@
package prrs_pkg;

    localparam int PRRS_MAX_PROCS    = 16;
    localparam int PRRS_RESULT_LIMIT = 16;

    localparam int PID_W  = 16;
    localparam int ID_W   = 17;
    localparam int ARR_W  = 16;
    localparam int WORK_W = 16;
    localparam int PRIO_W = 8;
    localparam int TIME_W = 21;
    localparam int NREP_W = $clog2(PRRS_RESULT_LIMIT + 1);

    typedef struct packed {
        logic [ID_W-1:0]   pid;
        logic [ARR_W-1:0]  arrive;
        logic [WORK_W-1:0] work;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic load;
        logic sort_init;
        logic sort_fetch;
        logic sort_hold;
        logic sort_shift;
        logic sort_place;
        logic run_fetch;
        logic run_exec;
        logic flush_out;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic acc_last;
        logic sort_done;
        logic hold_gt;
        logic k_one;
        logic run_done;
        logic exec_stall;
        logic pend_valid;
        logic out_free;
    } t_stat;

endpackage

@@ hdl/prrs_rec_if.sv @@
interface prrs_rec_if import prrs_pkg::*;;
    logic              valid;
    logic              ready;
    logic [PID_W-1:0]  proc_id;
    logic [ARR_W-1:0]  arrival_time;
    logic [WORK_W-1:0] work_units;
    logic [PRIO_W-1:0] priority_req;
    logic              last_record;

    modport source (
        output valid, proc_id, arrival_time, work_units, priority_req, last_record,
        input  ready
    );
    modport sink (
        input  valid, proc_id, arrival_time, work_units, priority_req, last_record,
        output ready
    );
endinterface

@@ hdl/prrs_res_if.sv @@
interface prrs_res_if import prrs_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   done_id;
    logic [TIME_W-1:0] finish_time;
    logic              last_result;

    modport source (
        output valid, done_id, finish_time, last_result,
        input  ready
    );
    modport sink (
        input  valid, done_id, finish_time, last_result,
        output ready
    );
endinterface

@@ hdl/priority_round_robin_scheduler.sv @@
// channel  | dir | handshake    | payload
// i_rec    | in  | valid/ready  | proc_id, arrival_time, work_units, priority_req, last_record
// o_res    | out | valid/ready  | done_id, finish_time, last_result
//
// loading takes one cycle per record; the table has a single write and a single read port
// sort: fetch, hold, compare/shift, place per entry; run: fetch, exec per visited entry
// a new batch loads once the last result of the run sits in the output register
// a stalled output holds the walk only when a second finished entry is waiting
// i_rst_n is synchronous; table contents are not cleared
module priority_round_robin_scheduler import prrs_pkg::*; #(
    parameter int MAX_PROCS = PRRS_MAX_PROCS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prrs_rec_if.sink   i_rec,
    prrs_res_if.source o_res
);

    t_cmd  cmd;
    t_stat stat;

    prrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    prrs_datapath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_rec   (i_rec),
        .o_res   (o_res)
    );

endmodule

@@ hdl/prrs_datapath.sv @@
module prrs_datapath import prrs_pkg::*; #(
    parameter int MAX_PROCS = PRRS_MAX_PROCS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    prrs_rec_if.sink  i_rec,
    prrs_res_if.source o_res
);

    localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);

    t_entry r_mem [MAX_PROCS];
    t_entry r_rdata;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          wr_en;

    logic [CW-1:0]     r_count, n_count;
    logic [TIME_W-1:0] r_remain, n_remain;
    logic [TIME_W-1:0] r_time, n_time;
    logic [AW-1:0]     r_scan, n_scan;
    logic [ID_W-1:0]   r_prev, n_prev;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_k, n_k;
    logic              r_ran, n_ran;
    logic [NREP_W-1:0] r_nrep, n_nrep;
    logic              r_pend_valid, n_pend_valid;
    logic              r_out_valid, n_out_valid;
    t_entry            r_held, n_held;
    logic [ID_W-1:0]   r_pend_id, n_pend_id;
    logic [TIME_W-1:0] r_pend_time, n_pend_time;
    logic [ID_W-1:0]   r_out_id, n_out_id;
    logic [TIME_W-1:0] r_out_time, n_out_time;
    logic              r_out_last, n_out_last;

    logic            acc;
    logic            room;
    logic            do_store;
    logic [ID_W-1:0] in_pid;
    logic [ID_W-1:0] pid_eff;
    logic            cond;
    logic            report;
    logic            out_free;
    logic [CW-1:0]   scan_inc;
    logic            last_pos;

    assign i_rec.ready = i_cmd.load;
    assign acc         = i_rec.valid && i_rec.ready;
    assign room        = r_count < CW'(MAX_PROCS);
    assign do_store    = acc && room;
    assign in_pid      = {1'b0, i_rec.proc_id};
    assign pid_eff     = (r_count != '0 && in_pid == r_prev) ? in_pid + ID_W'(1) : in_pid;

    assign cond     = (TIME_W'(r_rdata.arrive) <= r_time) && (r_rdata.work != '0);
    assign report   = cond && (r_rdata.work == WORK_W'(1))
                      && (r_nrep < NREP_W'(PRRS_RESULT_LIMIT));
    assign out_free = !r_out_valid || o_res.ready;
    assign scan_inc = CW'(r_scan) + CW'(1);
    assign last_pos = scan_inc >= r_count;

    assign o_stat.acc_last   = acc && i_rec.last_record;
    assign o_stat.sort_done  = r_i >= r_count;
    assign o_stat.hold_gt    = r_held.prio > r_rdata.prio;
    assign o_stat.k_one      = r_k == CW'(1);
    assign o_stat.run_done   = r_remain == '0;
    assign o_stat.exec_stall = report && r_pend_valid && !out_free;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = out_free;

    assign o_res.valid       = r_out_valid;
    assign o_res.done_id     = r_out_id;
    assign o_res.finish_time = r_out_time;
    assign o_res.last_result = r_out_last;

    // table write port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_rdata;
        priority if (do_store) begin
            wr_en        = 1'b1;
            wr_addr      = r_count[AW-1:0];
            wr_data.pid    = pid_eff;
            wr_data.arrive = i_rec.arrival_time;
            wr_data.work   = i_rec.work_units;
            wr_data.prio   = i_rec.priority_req;
        end else if (i_cmd.sort_shift) begin
            wr_en   = 1'b1;
            wr_addr = r_k[AW-1:0];
            wr_data = r_rdata;
        end else if (i_cmd.sort_place) begin
            wr_en   = 1'b1;
            wr_addr = r_k[AW-1:0];
            wr_data = r_held;
        end else if (i_cmd.run_exec && cond) begin
            wr_en        = 1'b1;
            wr_addr      = r_scan;
            wr_data.work = r_rdata.work - WORK_W'(1);
        end
    end

    // a stalled walk keeps re-reading the entry it is visiting
    always_comb begin
        rd_addr = r_scan;
        priority if (i_cmd.sort_fetch) begin
            rd_addr = r_i[AW-1:0];
        end else if (i_cmd.sort_hold) begin
            rd_addr = AW'(r_i - CW'(1));
        end else if (i_cmd.sort_shift) begin
            rd_addr = AW'(r_k - CW'(2));
        end else if (i_cmd.run_fetch) begin
            rd_addr = r_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        n_count      = r_count;
        n_remain     = r_remain;
        n_time       = r_time;
        n_scan       = r_scan;
        n_prev       = r_prev;
        n_i          = r_i;
        n_k          = r_k;
        n_ran        = r_ran;
        n_nrep       = r_nrep;
        n_pend_valid = r_pend_valid;
        n_out_valid  = r_out_valid;
        n_held       = r_held;
        n_pend_id    = r_pend_id;
        n_pend_time  = r_pend_time;
        n_out_id     = r_out_id;
        n_out_time   = r_out_time;
        n_out_last   = r_out_last;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        if (do_store) begin
            n_prev   = pid_eff;
            n_remain = r_remain + TIME_W'(i_rec.work_units);
            n_count  = r_count + CW'(1);
        end

        if (i_cmd.sort_init) begin
            n_i = CW'(1);
        end
        if (i_cmd.sort_hold) begin
            n_held = r_rdata;
            n_k    = r_i;
        end
        if (i_cmd.sort_shift) begin
            n_k = r_k - CW'(1);
        end
        if (i_cmd.sort_place) begin
            n_i = r_i + CW'(1);
        end

        if (i_cmd.run_exec) begin
            if (cond) begin
                n_remain = r_remain - TIME_W'(1);
            end
            if (report) begin
                if (r_pend_valid) begin
                    n_out_valid = 1'b1;
                    n_out_id    = r_pend_id;
                    n_out_time  = r_pend_time;
                    n_out_last  = 1'b0;
                end
                n_pend_valid = 1'b1;
                n_pend_id    = r_rdata.pid;
                n_pend_time  = r_time;
                n_nrep       = r_nrep + NREP_W'(1);
            end
            // idle sweep also advances time
            n_time = r_time + TIME_W'(cond) + TIME_W'(last_pos && !(r_ran || cond));
            n_ran  = last_pos ? 1'b0 : (r_ran || cond);
            n_scan = last_pos ? '0 : scan_inc[AW-1:0];
        end

        if (i_cmd.flush_out) begin
            n_out_valid = 1'b1;
            n_out_id    = r_pend_id;
            n_out_time  = r_pend_time;
            n_out_last  = 1'b1;
        end

        if (i_cmd.clear) begin
            n_count      = '0;
            n_remain     = '0;
            n_time       = TIME_W'(1);
            n_scan       = '0;
            n_prev       = '0;
            n_ran        = 1'b0;
            n_nrep       = '0;
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_remain     <= '0;
            r_time       <= TIME_W'(1);
            r_scan       <= '0;
            r_prev       <= '0;
            r_i          <= '0;
            r_k          <= '0;
            r_ran        <= 1'b0;
            r_nrep       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_remain     <= n_remain;
            r_time       <= n_time;
            r_scan       <= n_scan;
            r_prev       <= n_prev;
            r_i          <= n_i;
            r_k          <= n_k;
            r_ran        <= n_ran;
            r_nrep       <= n_nrep;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held      <= n_held;
        r_pend_id   <= n_pend_id;
        r_pend_time <= n_pend_time;
        r_out_id    <= n_out_id;
        r_out_time  <= n_out_time;
        r_out_last  <= n_out_last;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PROCS))
        else $error("entry count above table depth");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 |-> CW'(r_scan) < r_count)
        else $error("scan position outside loaded entries");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.run_exec && report && r_pend_valid) |-> out_free)
        else $error("pending result pushed into a busy output register");

    a_rep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nrep <= NREP_W'(PRRS_RESULT_LIMIT))
        else $error("report count above limit");

    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_count == '0 && r_time == TIME_W'(1) && !r_pend_valid))
        else $error("run state not restored after a run");

endmodule

@@ hdl/prrs_ctrl.sv @@
module prrs_ctrl import prrs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_LOAD       = 8'b0000_0001,
        S_SORT_FETCH = 8'b0000_0010,
        S_SORT_HOLD  = 8'b0000_0100,
        S_SORT_CMP   = 8'b0000_1000,
        S_SORT_PUT   = 8'b0001_0000,
        S_RUN_FETCH  = 8'b0010_0000,
        S_RUN_EXEC   = 8'b0100_0000,
        S_FLUSH      = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_stat.acc_last) begin
                    o_cmd.sort_init = 1'b1;
                    n_state         = S_SORT_FETCH;
                end
            end
            S_SORT_FETCH: begin
                if (i_stat.sort_done) begin
                    n_state = S_RUN_FETCH;
                end else begin
                    o_cmd.sort_fetch = 1'b1;
                    n_state          = S_SORT_HOLD;
                end
            end
            S_SORT_HOLD: begin
                o_cmd.sort_hold = 1'b1;
                n_state         = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                if (i_stat.hold_gt) begin
                    o_cmd.sort_shift = 1'b1;
                    if (i_stat.k_one) begin
                        n_state = S_SORT_PUT;
                    end
                end else begin
                    o_cmd.sort_place = 1'b1;
                    n_state          = S_SORT_FETCH;
                end
            end
            S_SORT_PUT: begin
                o_cmd.sort_place = 1'b1;
                n_state          = S_SORT_FETCH;
            end
            S_RUN_FETCH: begin
                if (i_stat.run_done) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.run_fetch = 1'b1;
                    n_state         = S_RUN_EXEC;
                end
            end
            S_RUN_EXEC: begin
                if (!i_stat.exec_stall) begin
                    o_cmd.run_exec = 1'b1;
                    n_state        = S_RUN_FETCH;
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_valid) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_LOAD;
                end else if (i_stat.out_free) begin
                    o_cmd.flush_out = 1'b1;
                    o_cmd.clear     = 1'b1;
                    n_state         = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ verif/prrs_checker.sv @@
module prrs_checker import prrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    prrs_rec_if  rec,
    prrs_res_if  res,
    output int   o_err_count,
    output int   o_open_count
);

    typedef struct packed {
        logic [ID_W-1:0]   done_id;
        logic [TIME_W-1:0] finish_time;
        logic              last_result;
    } t_done;

    t_entry            proc_tbl [PRRS_MAX_PROCS];
    int                n_loaded;
    logic [TIME_W-1:0] work_left;
    logic [ID_W-1:0]   last_id;
    t_done             done_q [$];

    function automatic void sort_by_prio();
        t_entry held;
        int     k;
        for (int i = 1; i < n_loaded; i++) begin
            held = proc_tbl[i];
            k = i;
            while (k > 0 && held.prio > proc_tbl[k-1].prio) begin
                proc_tbl[k] = proc_tbl[k-1];
                k--;
            end
            proc_tbl[k] = held;
        end
    endfunction

    // cyclic walk over the sorted table, one work unit per visit of an arrived entry with work left
    function automatic void run_batch();
        logic [TIME_W-1:0] now;
        int                pos;
        int                reports;
        bit                ran;
        t_done             d;
        now = TIME_W'(1);
        pos = 0;
        reports = 0;
        ran = 1'b0;
        while (work_left != 0 && n_loaded > 0) begin
            if (TIME_W'(proc_tbl[pos].arrive) <= now && proc_tbl[pos].work != 0) begin
                proc_tbl[pos].work = proc_tbl[pos].work - 1'b1;
                work_left = work_left - 1'b1;
                if (proc_tbl[pos].work == 0 && reports < PRRS_RESULT_LIMIT) begin
                    d.done_id     = proc_tbl[pos].pid;
                    d.finish_time = now;
                    d.last_result = 1'b0;
                    done_q.push_back(d);
                    reports++;
                end
                now = now + 1'b1;
                ran = 1'b1;
            end
            if (pos + 1 < n_loaded) begin
                pos++;
            end else begin
                pos = 0;
                if (!ran) now = now + 1'b1;
                ran = 1'b0;
            end
        end
        if (reports > 0) begin
            d = done_q.pop_back();
            d.last_result = 1'b1;
            done_q.push_back(d);
        end
        n_loaded  = 0;
        work_left = '0;
        last_id   = '0;
    endfunction

    function automatic void take_record();
        logic [ID_W-1:0] pid;
        if (n_loaded < PRRS_MAX_PROCS) begin
            pid = {1'b0, rec.proc_id};
            // repeated id is bumped against the stored id of the previous record
            if (n_loaded > 0 && pid == last_id) pid = pid + 1'b1;
            proc_tbl[n_loaded] = '{pid, rec.arrival_time, rec.work_units, rec.priority_req};
            last_id   = pid;
            work_left = work_left + TIME_W'(rec.work_units);
            n_loaded++;
        end
        if (rec.last_record) begin
            sort_by_prio();
            run_batch();
        end
    endfunction

    function automatic void check_done();
        t_done want;
        if (done_q.size() == 0) begin
            o_err_count++;
            if (o_err_count <= 10)
                $display("unexpected result: done_id %0d finish_time %0d last %0b",
                         res.done_id, res.finish_time, res.last_result);
        end else begin
            want = done_q.pop_front();
            if (res.done_id !== want.done_id || res.finish_time !== want.finish_time ||
                res.last_result !== want.last_result) begin
                o_err_count++;
                if (o_err_count <= 10)
                    $display({"mismatch: done_id exp %0d got %0d, ",
                              "finish_time exp %0d got %0d, last exp %0b got %0b"},
                             want.done_id, res.done_id, want.finish_time, res.finish_time,
                             want.last_result, res.last_result);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_loaded  = 0;
            work_left = '0;
            last_id   = '0;
            done_q.delete();
        end else begin
            if (res.valid === 1'b1 && res.ready === 1'b1) check_done();
            if (rec.valid === 1'b1 && rec.ready === 1'b1) take_record();
        end
        o_open_count = done_q.size();
    end

endmodule

@@ verif/tb_top.sv @@
module tb_top import prrs_pkg::*;;

    localparam int RANDOM_ITEMS = 440;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 800000;

    typedef struct packed {
        logic [PID_W-1:0]  proc_id;
        logic [ARR_W-1:0]  arrival_time;
        logic [WORK_W-1:0] work_units;
        logic [PRIO_W-1:0] priority_req;
        logic              last_record;
    } t_record;

    logic i_clk;
    logic i_rst_n;

    prrs_rec_if rec_if ();
    prrs_res_if res_if ();

    int err_count;
    int open_count;
    int gap_pct;
    int stall_pct;
    bit hold_req;
    bit hold_used;
    int hold_left;
    int quiet_cycles;
    int random_sent;
    logic [PID_W-1:0] prev_pid;

    priority_round_robin_scheduler u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_if),
        .o_res   (res_if)
    );

    prrs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .rec          (rec_if),
        .res          (res_if),
        .o_err_count  (err_count),
        .o_open_count (open_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (hold_req && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((rec_if.valid === 1'b1 && rec_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && res_if.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("priority_round_robin_scheduler verification failed");
            $finish;
        end
    end

    task automatic push_record(input t_record r);
        while ($urandom_range(99) < gap_pct) begin
            rec_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        rec_if.valid        <= 1'b1;
        rec_if.proc_id      <= r.proc_id;
        rec_if.arrival_time <= r.arrival_time;
        rec_if.work_units   <= r.work_units;
        rec_if.priority_req <= r.priority_req;
        rec_if.last_record  <= r.last_record;
        do @(posedge i_clk); while (rec_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        rec_if.valid <= 1'b0;
        do @(negedge i_clk); while (open_count != 0);
    endtask

    task automatic random_batch();
        t_record r;
        int      n;
        int      roll;
        roll = $urandom_range(99);
        if (roll < 80)      n = $urandom_range(8, 1);
        else if (roll < 95) n = $urandom_range(16, 9);
        else                n = $urandom_range(20, 17);
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (i > 0 && roll < 25)      r.proc_id = prev_pid;
            else if (i > 0 && roll < 35) r.proc_id = prev_pid + 1'b1;
            else                         r.proc_id = PID_W'($urandom);
            prev_pid = r.proc_id;
            roll = $urandom_range(99);
            if (roll < 70)      r.arrival_time = ARR_W'($urandom_range(12));
            else if (roll < 95) r.arrival_time = ARR_W'($urandom_range(60));
            else                r.arrival_time = ARR_W'($urandom_range(400));
            roll = $urandom_range(99);
            if (roll < 15)      r.work_units = '0;
            else if (roll < 80) r.work_units = WORK_W'($urandom_range(6, 1));
            else                r.work_units = WORK_W'($urandom_range(30, 7));
            r.priority_req = $urandom_range(1) ? PRIO_W'($urandom_range(3))
                                               : PRIO_W'($urandom_range(255));
            r.last_record = (i == n - 1);
            push_record(r);
            random_sent++;
        end
    endtask

    initial begin
        rec_if.valid        = 1'b0;
        rec_if.proc_id      = '0;
        rec_if.arrival_time = '0;
        rec_if.work_units   = '0;
        rec_if.priority_req = '0;
        rec_if.last_record  = 1'b0;
        res_if.ready        = 1'b0;
        i_rst_n             = 1'b0;
        gap_pct             = 0;
        stall_pct           = 0;
        hold_req            = 1'b0;
        hold_used           = 1'b0;
        hold_left           = 0;
        quiet_cycles        = 0;
        random_sent         = 0;
        prev_pid            = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first record equals the cleared stored id, chained duplicates, id wrap to bit 16
        push_record('{16'h0000, 16'd0, 16'd2, 8'd5, 1'b0});
        push_record('{16'h0000, 16'd1, 16'd3, 8'd5, 1'b0});
        push_record('{16'h0001, 16'd0, 16'd1, 8'd9, 1'b0});
        push_record('{16'hFFFF, 16'd2, 16'd2, 8'hFF, 1'b0});
        push_record('{16'hFFFF, 16'd0, 16'd1, 8'h00, 1'b1});
        // no work at all, no report
        push_record('{16'h0003, 16'd0, 16'd0, 8'd1, 1'b0});
        push_record('{16'h0004, 16'd5, 16'd0, 8'd2, 1'b1});
        // one record over a full table, still starts the run
        for (int i = 0; i < 17; i++)
            push_record('{PID_W'(i * 3), ARR_W'(i % 5), WORK_W'(1 + i % 3),
                          PRIO_W'(i % 4), (i == 16)});
        // late arrival forces idle passes
        push_record('{16'h1234, 16'hFFFF, 16'd1, 8'h80, 1'b1});
        push_record('{16'hABCD, 16'h0000, 16'hFFFF, 8'h7F, 1'b1});
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    gap_pct = 0;
                    stall_pct <= 0;
                    hold_req <= 1'b1;
                end
                1: begin
                    gap_pct = 68;
                    stall_pct <= 0;
                end
                2: begin
                    gap_pct = 0;
                    stall_pct <= 68;
                end
                default: begin
                    gap_pct = 28;
                    stall_pct <= 28;
                end
            endcase
            while (random_sent < (ph + 1) * RANDOM_ITEMS / 4) random_batch();
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && open_count == 0) begin
            $display("priority_round_robin_scheduler verification clean");
        end else begin
            $display("priority_round_robin_scheduler verification failed");
        end
        $finish;
    end

endmodule
